// ===== sv/cau_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cau_pkg
// Shared types, constants and helper functions of the complex arithmetic unit.
// ============================================================================
package cau_pkg;

    // Fixed-point format and derived sizes
    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = 64 + FRAC_BITS;   // one quotient bit per cell
    localparam int Q_W       = 33;               // quotient bits kept per lane
    localparam int MQ_W      = 64 - FRAC_BITS;   // product magnitude after scaling

    localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

    // Operation codes
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_EQ  = 4'd4;
    localparam logic [3:0] OP_NE  = 4'd5;
    localparam logic [3:0] OP_GT  = 4'd6;
    localparam logic [3:0] OP_LT  = 4'd7;
    localparam logic [3:0] OP_GE  = 4'd8;
    localparam logic [3:0] OP_LE  = 4'd9;

    // One divider lane: remaining numerator bits, partial remainder, quotient, overflow flag
    typedef struct packed {
        logic [63:0]    num;
        logic [63:0]    rem;
        logic [Q_W-1:0] q;
        logic           ovf;
    } t_lane;

    // Result fields that ride along with a word through the divider chain
    typedef struct packed {
        logic               is_div;
        logic               neg_re;
        logic               neg_im;
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               cmp;
        logic               dz;
        logic               sat;
    } t_side;

    // Contents of one divider cell
    typedef struct packed {
        t_side       side;
        logic [63:0] den;
        t_lane       re;
        t_lane       im;
    } t_cell;

    // Clipped result part
    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_fin;

    // One restoring division step: shift in a numerator bit, subtract if it fits
    function automatic t_lane div_step(t_lane l, logic [63:0] den);
        logic [64:0] shifted;
        logic        fits;
        logic [64:0] diff;
        t_lane       r;
        shifted = {l.rem, l.num[63]};
        fits    = (shifted >= {1'b0, den});
        diff    = shifted - {1'b0, den};
        r.num   = {l.num[62:0], 1'b0};
        r.rem   = fits ? diff[63:0] : shifted[63:0];
        r.q     = {l.q[Q_W-2:0], fits};
        r.ovf   = l.ovf | l.q[Q_W-1];
        return r;
    endfunction

    // Apply sign to a truncated magnitude, flooring negatives, and clip to 32 bits
    function automatic t_fin finish(logic neg, logic [MQ_W-1:0] q, logic inexact);
        logic [MQ_W:0] qq;
        t_fin          f;
        qq    = {1'b0, q} + {{MQ_W{1'b0}}, inexact};
        f.sat = 1'b0;
        f.val = '0;
        if (!neg) begin
            if (q > MQ_W'(32'h7FFF_FFFF)) begin
                f.sat = 1'b1;
                f.val = 32'sh7FFF_FFFF;
            end else begin
                f.val = q[31:0];
            end
        end else begin
            if (qq > (MQ_W+1)'(32'h8000_0000)) begin
                f.sat = 1'b1;
                f.val = 32'sh8000_0000;
            end else begin
                f.val = 32'd0 - qq[31:0];
            end
        end
        return f;
    endfunction

endpackage

// ===== sv/cau_div_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cau_div_cell
// One divider cell: produces one quotient bit for both lanes of a word and
// hands the word to the next cell.
// ============================================================================
module cau_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  cau_pkg::t_cell i_cell,
    output logic          o_vld,
    output cau_pkg::t_cell o_cell
);
    import cau_pkg::*;

    logic  r_vld;
    t_cell r_cell;
    t_cell n_cell;

    // Step both lanes against the shared divisor
    always_comb begin
        n_cell      = i_cell;
        n_cell.re   = div_step(i_cell.re, i_cell.den);
        n_cell.im   = div_step(i_cell.im, i_cell.den);
    end

    // Clear valid under reset, advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_vld  = r_vld;
    assign o_cell = r_cell;

endmodule

// ===== sv/cau_div_chain.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cau_div_chain
// Row of divider cells, one per quotient bit; a word moves one cell per cycle while i_en is high.
// ============================================================================
module cau_div_chain (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  cau_pkg::t_cell i_cell,
    output logic          o_vld,
    output cau_pkg::t_cell o_cell
);
    import cau_pkg::*;

    logic  w_vld  [0:DIV_STEPS];
    t_cell w_cell [0:DIV_STEPS];

    assign w_vld[0]  = i_vld;
    assign w_cell[0] = i_cell;

    // Build the row of cells
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_vld   (w_vld[g]),
            .i_cell  (w_cell[g]),
            .o_vld   (w_vld[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    assign o_vld  = w_vld[DIV_STEPS];
    assign o_cell = w_cell[DIV_STEPS];

endmodule

// ===== sv/complex_arith_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// complex_arith_unit
// Complex ALU on signed Q16.16: add, sub, mul, div, equality and magnitude compares.
// ============================================================================
//  channel | dir | tdata (low bit up)                  | tuser (low bit up)
//  s_axis  | in  | a_re, a_im, b_re, b_im (128 bits)   | op (4 bits)
//  m_axis  | out | res_re, res_im, cmp_true, 7 zeros   | div_zero, saturated
//
//  One word accepted per cycle unless the pipeline holds; every word passes through
//  input register, multiply, sum, magnitude, finish, 80 divider cells, output.
//  The divider row, one quotient bit per cell, sets the latency for all ops.
//  Reset is synchronous, active low, and clears valid bits only.
//  The whole pipeline holds while an output word waits; s_axis_tready is high
//  whenever the output register is empty or being taken.
// ============================================================================
module complex_arith_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // a_re, a_im, b_re, b_im
    input  logic [3:0]   s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // res_re, res_im, cmp_true, zero pad
    output logic [1:0]   m_axis_tuser    // div_zero, saturated
);
    import cau_pkg::*;

    logic en;

    // Pipeline moves when the output register is free or being drained
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- stage 0: input register
    logic               r0_vld;
    logic [3:0]         r0_op;
    logic signed [31:0] r0_ar, r0_ai, r0_br, r0_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_op <= s_axis_tuser;
            r0_ar <= s_axis_tdata[31:0];
            r0_ai <= s_axis_tdata[63:32];
            r0_br <= s_axis_tdata[95:64];
            r0_bi <= s_axis_tdata[127:96];
        end
    end

    // ---------------- stage 1: products
    logic               r1_vld;
    logic [3:0]         r1_op;
    logic signed [31:0] r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [63:0] r1_arbr, r1_aibi, r1_arbi, r1_aibr;
    logic signed [63:0] r1_arar, r1_aiai, r1_brbr, r1_bibi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op   <= r0_op;
            r1_ar   <= r0_ar;
            r1_ai   <= r0_ai;
            r1_br   <= r0_br;
            r1_bi   <= r0_bi;
            r1_arbr <= r0_ar * r0_br;
            r1_aibi <= r0_ai * r0_bi;
            r1_arbi <= r0_ar * r0_bi;
            r1_aibr <= r0_ai * r0_br;
            r1_arar <= r0_ar * r0_ar;
            r1_aiai <= r0_ai * r0_ai;
            r1_brbr <= r0_br * r0_br;
            r1_bibi <= r0_bi * r0_bi;
        end
    end

    // ---------------- stage 2: sums of products, squared magnitudes
    logic               r2_vld;
    logic [3:0]         r2_op;
    logic signed [31:0] r2_ar, r2_ai, r2_br, r2_bi;
    logic signed [64:0] r2_v_re, r2_v_im;
    logic [63:0]        r2_mag_a, r2_mag_b;
    logic signed [64:0] x_arbr, x_aibi, x_arbi, x_aibr;

    assign x_arbr = 65'(r1_arbr);
    assign x_aibi = 65'(r1_aibi);
    assign x_arbi = 65'(r1_arbi);
    assign x_aibr = 65'(r1_aibr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op    <= r1_op;
            r2_ar    <= r1_ar;
            r2_ai    <= r1_ai;
            r2_br    <= r1_br;
            r2_bi    <= r1_bi;
            r2_v_re  <= (r1_op == OP_DIV) ? x_arbr + x_aibi : x_arbr - x_aibi;
            r2_v_im  <= (r1_op == OP_DIV) ? x_aibr - x_arbi : x_arbi + x_aibr;
            r2_mag_a <= r1_arar + r1_aiai;
            r2_mag_b <= r1_brbr + r1_bibi;
        end
    end

    // ---------------- stage 3: sign and magnitude, compares, add/sub
    logic               r3_vld;
    logic [3:0]         r3_op;
    logic signed [31:0] r3_ar, r3_ai;
    logic               r3_bzero;
    logic               r3_neg_re, r3_neg_im;
    logic [63:0]        r3_m_re, r3_m_im, r3_den;
    logic               r3_gt, r3_lt, r3_eq;
    t_fin               r3_as_re, r3_as_im;
    logic signed [32:0] s_re, s_im;
    logic signed [64:0] abs_re, abs_im;
    t_fin               c_re, c_im;

    // Add or subtract each part with one spare bit, then clip
    always_comb begin
        if (r2_op == OP_SUB) begin
            s_re = 33'(r2_ar) - 33'(r2_br);
            s_im = 33'(r2_ai) - 33'(r2_bi);
        end else begin
            s_re = 33'(r2_ar) + 33'(r2_br);
            s_im = 33'(r2_ai) + 33'(r2_bi);
        end
        c_re.sat = (s_re[32] != s_re[31]);
        c_re.val = c_re.sat ? (s_re[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : s_re[31:0];
        c_im.sat = (s_im[32] != s_im[31]);
        c_im.val = c_im.sat ? (s_im[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : s_im[31:0];
        abs_re   = r2_v_re[64] ? -r2_v_re : r2_v_re;
        abs_im   = r2_v_im[64] ? -r2_v_im : r2_v_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_op     <= r2_op;
            r3_ar     <= r2_ar;
            r3_ai     <= r2_ai;
            r3_bzero  <= (r2_br == 32'sd0) && (r2_bi == 32'sd0);
            r3_neg_re <= r2_v_re[64];
            r3_neg_im <= r2_v_im[64];
            r3_m_re   <= abs_re[63:0];
            r3_m_im   <= abs_im[63:0];
            r3_den    <= r2_mag_b;
            r3_gt     <= r2_mag_a > r2_mag_b;
            r3_lt     <= r2_mag_a < r2_mag_b;
            r3_eq     <= (r2_ar == r2_br) && (r2_ai == r2_bi);
            r3_as_re  <= c_re;
            r3_as_im  <= c_im;
        end
    end

    // ---------------- stage 4: finish non-divide results, load divider word
    logic  r4_vld;
    t_cell r4_cell;
    t_cell n4_cell;
    t_fin  m_re, m_im;

    always_comb begin
        m_re = finish(r3_neg_re, r3_m_re[63:FRAC_BITS], |(r3_m_re & FRAC_MASK));
        m_im = finish(r3_neg_im, r3_m_im[63:FRAC_BITS], |(r3_m_im & FRAC_MASK));

        n4_cell             = '0;
        n4_cell.den         = r3_den;
        n4_cell.re.num      = r3_m_re;
        n4_cell.im.num      = r3_m_im;
        n4_cell.side.neg_re = r3_neg_re;
        n4_cell.side.neg_im = r3_neg_im;

        unique case (r3_op)
            OP_ADD, OP_SUB: begin
                n4_cell.side.res_re = r3_as_re.val;
                n4_cell.side.res_im = r3_as_im.val;
                n4_cell.side.sat    = r3_as_re.sat | r3_as_im.sat;
            end
            OP_MUL: begin
                n4_cell.side.res_re = m_re.val;
                n4_cell.side.res_im = m_im.val;
                n4_cell.side.sat    = m_re.sat | m_im.sat;
            end
            OP_DIV: begin
                // zero divisor returns A unchanged
                if (r3_bzero) begin
                    n4_cell.side.res_re = r3_ar;
                    n4_cell.side.res_im = r3_ai;
                    n4_cell.side.dz     = 1'b1;
                end else begin
                    n4_cell.side.is_div = 1'b1;
                end
            end
            OP_EQ:   n4_cell.side.cmp = r3_eq;
            OP_NE:   n4_cell.side.cmp = !r3_eq;
            OP_GT:   n4_cell.side.cmp = r3_gt;
            OP_LT:   n4_cell.side.cmp = r3_lt;
            OP_GE:   n4_cell.side.cmp = !r3_lt;
            OP_LE:   n4_cell.side.cmp = !r3_gt;
            default: n4_cell.side.cmp = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_cell <= n4_cell;
        end
    end

    // ---------------- divider row
    logic  dv_vld;
    t_cell dv_cell;

    cau_div_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r4_vld),
        .i_cell  (r4_cell),
        .o_vld   (dv_vld),
        .o_cell  (dv_cell)
    );

    // ---------------- output register
    logic               r_out_vld;
    logic signed [31:0] r_res_re, r_res_im;
    logic               r_cmp, r_dz, r_sat;
    t_fin               d_re, d_im;
    logic [MQ_W-1:0]    q_re, q_im;

    // Saturate quotients that overflowed the kept bits
    always_comb begin
        q_re = dv_cell.re.ovf ? {MQ_W{1'b1}} : MQ_W'(dv_cell.re.q);
        q_im = dv_cell.im.ovf ? {MQ_W{1'b1}} : MQ_W'(dv_cell.im.q);
        d_re = finish(dv_cell.side.neg_re, q_re, |dv_cell.re.rem);
        d_im = finish(dv_cell.side.neg_im, q_im, |dv_cell.im.rem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmp <= dv_cell.side.cmp;
            r_dz  <= dv_cell.side.dz;
            if (dv_cell.side.is_div) begin
                r_res_re <= d_re.val;
                r_res_im <= d_im.val;
                r_sat    <= d_re.sat | d_im.sat;
            end else begin
                r_res_re <= dv_cell.side.res_re;
                r_res_im <= dv_cell.side.res_im;
                r_sat    <= dv_cell.side.sat;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_cmp, r_res_im, r_res_re};
    assign m_axis_tuser  = {r_sat, r_dz};

    // ---------------- assertions
    a_dz_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("div_zero and saturated both set");

    a_cmp_zero_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[64]) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("compare result carries nonzero data");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output register state");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r0_vld)
        else $error("accepted word missing from input register");

endmodule
